/* rtl/core/lcas_pkg.sv */
// shared types and constants for the life cellular automaton step block
package lcas_pkg;

  // register map, word index taken from paddr[2]
  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } lcas_reg_e;

  localparam int unsigned ColumnsReset = 100;
  localparam int unsigned RowsReset    = 30;
  localparam int unsigned MinDim       = 3;

  localparam int unsigned ColumnsRegW = 8;
  localparam int unsigned RowsRegW    = 11;
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned ApbAddrW    = 3;

  // b3/s23 rule
  localparam logic [3:0] BirthCount   = 4'd3;
  localparam logic [3:0] SurviveCount = 4'd2;

  // window bit = slot*3 + row; slot 0 left, row 0 top
  localparam logic [8:0] TopRowBits    = 9'h049;
  localparam logic [8:0] BottomRowBits = 9'h124;
  localparam int unsigned CentreBit    = 4;

  typedef struct packed {
    logic cell_req;
    logic flush;
  } lcas_in_t;

  typedef struct packed {
    logic       next_cell;
    logic [9:0] out_row;
    logic [6:0] out_column;
    logic       last_of_frame;
  } lcas_out_t;

  typedef struct packed {
    logic top;
    logic bottom;
  } lcas_mask_t;

endpackage

/* rtl/core/lcas_regs.sv */
// apb register file holding grid width and height, with clamped limits
module lcas_regs #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 1024,
  localparam int unsigned CidxW      = $clog2(MAX_COLUMNS),
  localparam int unsigned RidxW      = $clog2(MAX_ROWS)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lcas_pkg::ApbAddrW-1:0]      paddr,
  input  logic [lcas_pkg::ApbDataW-1:0]      pwdata,
  output logic [lcas_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  output logic [CidxW-1:0]                   last_col_o,
  output logic [RidxW-1:0]                   last_row_o,
  output logic                               restart_o
);

  localparam int unsigned WidthRst  = (lcas_pkg::ColumnsReset > MAX_COLUMNS) ?
                                      MAX_COLUMNS : lcas_pkg::ColumnsReset;
  localparam int unsigned HeightRst = (lcas_pkg::RowsReset > MAX_ROWS) ?
                                      MAX_ROWS : lcas_pkg::RowsReset;
  localparam logic [CidxW-1:0] LastColRst = CidxW'(WidthRst - 1);
  localparam logic [RidxW-1:0] LastRowRst = RidxW'(HeightRst - 1);

  logic [lcas_pkg::ColumnsRegW-1:0] cols_q, cols_d;
  logic [lcas_pkg::RowsRegW-1:0]    rows_q, rows_d;
  logic [CidxW-1:0]                 last_col_q, last_col_d;
  logic [RidxW-1:0]                 last_row_q, last_row_d;
  logic                             wr_en;
  lcas_pkg::lcas_reg_e              reg_sel;
  logic [31:0]                      cols32, rows32, lim_col32, lim_row32;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = lcas_pkg::lcas_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  // clamp to [3, max] and keep size minus one
  always_comb begin
    cols32 = {24'b0, pwdata[lcas_pkg::ColumnsRegW-1:0]};
    rows32 = {21'b0, pwdata[lcas_pkg::RowsRegW-1:0]};
    priority if (cols32 < 32'(lcas_pkg::MinDim)) begin
      lim_col32 = 32'(lcas_pkg::MinDim) - 32'd1;
    end else if (cols32 > 32'(MAX_COLUMNS)) begin
      lim_col32 = 32'(MAX_COLUMNS) - 32'd1;
    end else begin
      lim_col32 = cols32 - 32'd1;
    end
    priority if (rows32 < 32'(lcas_pkg::MinDim)) begin
      lim_row32 = 32'(lcas_pkg::MinDim) - 32'd1;
    end else if (rows32 > 32'(MAX_ROWS)) begin
      lim_row32 = 32'(MAX_ROWS) - 32'd1;
    end else begin
      lim_row32 = rows32 - 32'd1;
    end
  end

  always_comb begin
    cols_d     = cols_q;
    rows_d     = rows_q;
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    if (wr_en) begin
      unique case (reg_sel)
        lcas_pkg::REG_COLUMNS: begin
          cols_d     = pwdata[lcas_pkg::ColumnsRegW-1:0];
          last_col_d = lim_col32[CidxW-1:0];
        end
        lcas_pkg::REG_ROWS: begin
          rows_d     = pwdata[lcas_pkg::RowsRegW-1:0];
          last_row_d = lim_row32[RidxW-1:0];
        end
        default: begin
          cols_d = cols_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= lcas_pkg::ColumnsRegW'(lcas_pkg::ColumnsReset);
      rows_q     <= lcas_pkg::RowsRegW'(lcas_pkg::RowsReset);
      last_col_q <= LastColRst;
      last_row_q <= LastRowRst;
    end else begin
      cols_q     <= cols_d;
      rows_q     <= rows_d;
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      lcas_pkg::REG_COLUMNS: prdata = {24'b0, cols_q};
      lcas_pkg::REG_ROWS:    prdata = {21'b0, rows_q};
      default:               prdata = '0;
    endcase
  end

  assign last_col_o = last_col_q;
  assign last_row_o = last_row_q;
  assign restart_o  = wr_en;

endmodule

/* rtl/core/lcas_rule.sv */
// edge masking, neighbor count and b3/s23 rule on one 3x3 window
module lcas_rule (
  input  logic [8:0]           win_i,
  input  lcas_pkg::lcas_mask_t mask_i,
  output logic                 alive_o
);

  logic [8:0] masked;
  logic [3:0] count;

  always_comb begin
    masked = win_i;
    if (mask_i.top) begin
      masked = masked & ~lcas_pkg::TopRowBits;
    end
    if (mask_i.bottom) begin
      masked = masked & ~lcas_pkg::BottomRowBits;
    end
    count = '0;
    for (int b = 0; b < 9; b++) begin
      if (b != lcas_pkg::CentreBit) begin
        count = count + 4'(masked[b]);
      end
    end
    alive_o = (count == lcas_pkg::BirthCount) ||
              (masked[lcas_pkg::CentreBit] && (count == lcas_pkg::SurviveCount));
  end

endmodule

/* rtl/core/life_cellular_automaton_step.sv */
// top level: raster stream game of life step with row memory and 3x3 window
// result: registered in stage 1, then the output stage, after the transaction that completes its window,
//   which is the cell diagonally below-right (columns_in_use+1 transactions after the cell)
// throughput: one transaction per cycle unless the output stalls; row memory read overlaps write-back, with a bypass
// reset: counters, window and flush phase clear; registers return to 100 columns, 30 rows
// reset: the row memory is not cleared; stale rows only feed masked window bits
module life_cellular_automaton_step #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lcas_pkg::lcas_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lcas_pkg::lcas_out_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcas_pkg::ApbAddrW-1:0] paddr,
  input  logic [lcas_pkg::ApbDataW-1:0] pwdata,
  output logic [lcas_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned CidxW = $clog2(MAX_COLUMNS);
  localparam int unsigned RidxW = $clog2(MAX_ROWS);
  localparam int unsigned FcW   = $clog2(MAX_COLUMNS + 2);

  logic [CidxW-1:0] last_col;
  logic [RidxW-1:0] last_row;
  logic             cfg_restart;

  lcas_regs #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .last_col_o(last_col),
    .last_row_o(last_row),
    .restart_o (cfg_restart)
  );

  // frame counters
  logic [RidxW-1:0] in_row_q, in_row_d, emit_row_q, emit_row_d;
  logic [CidxW-1:0] in_col_q, in_col_d, emit_col_q, emit_col_d;
  logic [FcW-1:0]   fc_q, fc_d, width_fc;
  logic             flushing_q, flushing_d;

  // stage 1
  logic                 s1_valid_q;
  logic [CidxW-1:0]     s1_idx_q;
  logic                 s1_cell_q, s1_col0_q, s1_emit_q;
  lcas_pkg::lcas_mask_t s1_mask_q;
  lcas_pkg::lcas_out_t  s1_out_q;
  logic [1:0]           rd_q;

  // output stage
  logic                out_valid_q;
  lcas_pkg::lcas_out_t out_q;
  logic [8:0]          window_q, window_d, win;
  logic                alive;

  logic                 en1, en2, accept, s1_leave, slide, emit, cell_in, restart;
  logic [CidxW-1:0]     idx, ic_b, ec_b;
  logic [RidxW-1:0]     ir_b, er_b;
  lcas_pkg::lcas_mask_t mask;
  lcas_pkg::lcas_out_t  res;
  logic [31:0]          er32, ec32;
  logic [2:0]           vec;
  logic [1:0]           mem_wdata;

  logic [1:0] row_mem [MAX_COLUMNS];

  assign en2        = !out_valid_q || out_ready_i;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;
  assign s1_leave   = s1_valid_q && en2;
  assign width_fc   = FcW'(last_col) + FcW'(1);

  always_comb begin
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    emit_row_d = emit_row_q;
    emit_col_d = emit_col_q;
    fc_d       = fc_q;
    flushing_d = flushing_q;
    slide      = 1'b0;
    emit       = 1'b0;
    cell_in    = 1'b0;
    idx        = '0;
    restart    = flushing_q && !in_data_i.flush;
    ir_b       = restart ? '0 : in_row_q;
    ic_b       = restart ? '0 : in_col_q;
    er_b       = restart ? '0 : emit_row_q;
    ec_b       = restart ? '0 : emit_col_q;
    if (in_data_i.flush) begin
      if (flushing_q && (fc_q <= width_fc)) begin
        slide = 1'b1;
        emit  = 1'b1;
        idx   = (fc_q >= width_fc) ? '0 : fc_q[CidxW-1:0];
        fc_d  = fc_q + FcW'(1);
      end
    end else begin
      slide      = 1'b1;
      cell_in    = in_data_i.cell_req;
      idx        = ic_b;
      emit       = (ir_b != '0) && ((ic_b != '0) || (ir_b[RidxW-1:1] != '0));
      flushing_d = 1'b0;
      fc_d       = restart ? '0 : fc_q;
      emit_row_d = er_b;
      emit_col_d = ec_b;
      if (ic_b == last_col) begin
        in_col_d = '0;
        if (ir_b == last_row) begin
          in_row_d   = '0;
          flushing_d = 1'b1;
          fc_d       = '0;
        end else begin
          in_row_d = ir_b + RidxW'(1);
        end
      end else begin
        in_row_d = ir_b;
        in_col_d = ic_b + CidxW'(1);
      end
    end
    if (emit) begin
      if (ec_b == last_col) begin
        emit_col_d = '0;
        emit_row_d = er_b + RidxW'(1);
      end else begin
        emit_row_d = er_b;
        emit_col_d = ec_b + CidxW'(1);
      end
    end
    // last flush drains the frame
    if (in_data_i.flush && slide && (fc_q == width_fc)) begin
      in_row_d   = '0;
      in_col_d   = '0;
      emit_row_d = '0;
      emit_col_d = '0;
    end
  end

  always_comb begin
    mask.top          = (er_b == '0);
    mask.bottom       = (er_b == last_row);
    er32              = 32'(er_b);
    ec32              = 32'(ec_b);
    res.next_cell     = 1'b0;
    res.out_row       = er32[9:0];
    res.out_column    = ec32[6:0];
    res.last_of_frame = mask.bottom && (ec_b == last_col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
      fc_q       <= '0;
      flushing_q <= 1'b0;
    end else if (cfg_restart) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
      fc_q       <= '0;
      flushing_q <= 1'b0;
    end else if (accept) begin
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      emit_row_q <= emit_row_d;
      emit_col_q <= emit_col_d;
      fc_q       <= fc_d;
      flushing_q <= flushing_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= accept && slide;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && slide) begin
      s1_idx_q  <= idx;
      s1_cell_q <= cell_in;
      s1_col0_q <= (idx == '0);
      s1_emit_q <= emit;
      s1_mask_q <= mask;
      s1_out_q  <= res;
    end
  end

  // row memory: bit 0 older row, bit 1 newer row
  assign mem_wdata = {s1_cell_q, rd_q[1]};

  always_ff @(posedge clk_i) begin
    if (s1_leave) begin
      row_mem[s1_idx_q] <= mem_wdata;
    end
    if (accept && slide) begin
      if (s1_leave && (s1_idx_q == idx)) begin
        rd_q <= mem_wdata;
      end else begin
        rd_q <= row_mem[idx];
      end
    end
  end

  // window slide
  always_comb begin
    vec = {s1_cell_q, rd_q[1], rd_q[0]};
    if (s1_col0_q) begin
      win      = {3'b000, window_q[8:3]};
      window_d = {vec, 6'b000000};
    end else begin
      window_d = {vec, window_q[8:3]};
      win      = window_d;
    end
  end

  lcas_rule u_rule (
    .win_i  (win),
    .mask_i (s1_mask_q),
    .alive_o(alive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_leave) begin
        window_q <= window_d;
      end
      if (en2) begin
        out_valid_q <= s1_valid_q && s1_emit_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_leave && s1_emit_q) begin
      out_q <= {alive, s1_out_q.out_row, s1_out_q.out_column, s1_out_q.last_of_frame};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= width_fc + FcW'(1))
    else $error("flush count beyond frame drain");

  a_flush_counters_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> (in_row_q == '0) && (in_col_q == '0))
    else $error("input counters moved during flush phase");

  a_emit_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_col_q <= last_col) && (emit_row_q <= last_row))
    else $error("emit position outside grid");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !en2 |=> s1_valid_q && $stable(s1_idx_q) && $stable(s1_emit_q))
    else $error("stage one lost its transaction while stalled");
`endif

endmodule
